/* rtl/tvcc_pkg.sv */
// Shared types and constants of the calibrated temperature / supply converter.
package tvcc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMP_CAL = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VREF_CAL = 1'b1;

   localparam int TEMP_CAL_RESET = 1760;
   localparam int VREF_CAL_RESET = 1520;

   // opcodes; the unused code falls back to raw samples
   localparam logic [1:0] OP_CAL_WORDS = 2'd0;
   localparam logic [1:0] OP_RAW       = 2'd1;
   localparam logic [1:0] OP_CONVERT   = 2'd2;

   // conversion constants
   localparam int TEMP_OFFSET = 300;
   localparam int VOLT_SCALE  = 330;
   localparam int VOLT_BITS   = $clog2(VOLT_SCALE + 1);
   // 10000/5336 reduced by their common factor of 8
   localparam int GAIN_NUM    = 10000 / 8;
   localparam int GAIN_DEN    = 5336 / 8;

   // beyond this difference the temperature saturates either way
   localparam int D_CLAMP     = 20000;
   localparam int MAG_BITS    = $clog2(D_CLAMP + 1);
   localparam int X_BITS      = $clog2(D_CLAMP * GAIN_NUM + 1);
   localparam int RECIP_SHIFT = 32;
   localparam longint RECIP_VALUE = (64'd1 << RECIP_SHIFT) / GAIN_DEN;
   localparam int RECIP_BITS  = $clog2(RECIP_VALUE + 1);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VALUE);
   localparam int PROD_BITS   = X_BITS + RECIP_BITS;

   localparam int OUT_BITS = 16;
   localparam int OUT_MAX  = 32767;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,
      KIND_CONV  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } tag_type;

endpackage

/* rtl/tvcc_front.sv */
// Front end: calibration registers, opcode classification and numerator products.
module tvcc_front #(
   parameter int SAMPLE_BITS = tvcc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  logic [1:0]                                  req_opcode,
   input  logic [SAMPLE_BITS-1:0]                      req_temp_sample,
   input  logic [SAMPLE_BITS-1:0]                      req_vref_sample,
   input  logic                                        csr_write_enable,
   input  logic [tvcc_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [SAMPLE_BITS-1:0]                      csr_write_data,
   output tvcc_pkg::tag_type                           out_tag,
   output logic [SAMPLE_BITS-1:0]                      out_a,
   output logic [SAMPLE_BITS-1:0]                      out_b,
   output logic [SAMPLE_BITS-1:0]                      out_divisor,
   output logic [2*SAMPLE_BITS-1:0]                    out_num_q,
   output logic [SAMPLE_BITS+tvcc_pkg::VOLT_BITS-1:0]  out_num_v
);

   localparam int SB  = SAMPLE_BITS;
   localparam int NVB = SB + tvcc_pkg::VOLT_BITS;

   logic [SB-1:0]      temp_cal_ff, temp_cal_in;
   logic [SB-1:0]      vref_cal_ff, vref_cal_in;
   tvcc_pkg::tag_type  tag_ff, tag_in;
   logic [SB-1:0]      a_ff, a_in, b_ff, b_in, div_ff, div_in;
   logic [2*SB-1:0]    nq_ff, nq_in;
   logic [NVB-1:0]     nv_ff, nv_in;

   always_comb begin
      temp_cal_in = temp_cal_ff;
      vref_cal_in = vref_cal_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tvcc_pkg::CSR_TEMP_CAL: temp_cal_in = csr_write_data;
            tvcc_pkg::CSR_VREF_CAL: vref_cal_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      tag_in.valid = accept;
      div_in       = req_vref_sample;
      nq_in        = (2*SB)'(req_temp_sample) * (2*SB)'(vref_cal_ff);
      nv_in        = NVB'(vref_cal_ff) * NVB'(tvcc_pkg::VOLT_SCALE);
      case (req_opcode)
         tvcc_pkg::OP_CAL_WORDS: begin
            tag_in.kind = tvcc_pkg::KIND_PASS;
            a_in        = temp_cal_ff;
            b_in        = vref_cal_ff;
         end
         tvcc_pkg::OP_CONVERT: begin
            tag_in.kind = (req_vref_sample == '0) ? tvcc_pkg::KIND_FAULT
                                                  : tvcc_pkg::KIND_CONV;
            a_in        = temp_cal_ff;
            b_in        = vref_cal_ff;
         end
         default: begin
            tag_in.kind = tvcc_pkg::KIND_PASS;
            a_in        = req_temp_sample;
            b_in        = req_vref_sample;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= SB'(tvcc_pkg::TEMP_CAL_RESET);
         vref_cal_ff  <= SB'(tvcc_pkg::VREF_CAL_RESET);
         tag_ff.valid <= 1'b0;
      end else begin
         temp_cal_ff  <= temp_cal_in;
         vref_cal_ff  <= vref_cal_in;
         tag_ff.valid <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff.kind <= tag_in.kind;
      a_ff        <= a_in;
      b_ff        <= b_in;
      div_ff      <= div_in;
      nq_ff       <= nq_in;
      nv_ff       <= nv_in;
   end

   assign out_tag     = tag_ff;
   assign out_a       = a_ff;
   assign out_b       = b_ff;
   assign out_divisor = div_ff;
   assign out_num_q   = nq_ff;
   assign out_num_v   = nv_ff;

endmodule

/* rtl/tvcc_queue.sv */
// Short queue between front end and back end, registered read side.
module tvcc_queue #(
   parameter int DATA_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tvcc_pkg::tag_type      push_tag,
   input  logic [DATA_BITS-1:0]   push_data,
   output tvcc_pkg::tag_type      pop_tag,
   output logic [DATA_BITS-1:0]   pop_data,
   output logic                   full
);

   localparam int DEPTH    = tvcc_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   tvcc_pkg::kind_type    mem_kind [DEPTH];
   logic [DATA_BITS-1:0]  mem_data [DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   tvcc_pkg::tag_type     pop_tag_ff;
   logic [DATA_BITS-1:0]  pop_data_ff;
   logic                  push, pop;

   // back end never stalls: drain one beat whenever something is held
   assign push = push_tag.valid;
   assign pop  = (count_ff != '0);
   assign full = (count_ff == CNT_BITS'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
         pop_tag_ff.valid <= 1'b0;
      end else begin
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
         pop_tag_ff.valid <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_kind[wr_ptr_ff] <= push_tag.kind;
         mem_data[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      pop_tag_ff.kind <= mem_kind[rd_ptr_ff];
      pop_data_ff     <= mem_data[rd_ptr_ff];
   end

   assign pop_tag  = pop_tag_ff;
   assign pop_data = pop_data_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");
`endif

endmodule

/* rtl/tvcc_back.sv */
// Back end: pipelined restoring dividers, temperature scaling and result register.
module tvcc_back #(
   parameter int SAMPLE_BITS = tvcc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  tvcc_pkg::tag_type                           in_tag,
   input  logic [SAMPLE_BITS-1:0]                      in_a,
   input  logic [SAMPLE_BITS-1:0]                      in_b,
   input  logic [SAMPLE_BITS-1:0]                      in_divisor,
   input  logic [2*SAMPLE_BITS-1:0]                    in_num_q,
   input  logic [SAMPLE_BITS+tvcc_pkg::VOLT_BITS-1:0]  in_num_v,
   output logic                                        rsp_strobe,
   output logic signed [tvcc_pkg::OUT_BITS-1:0]        rsp_temperature,
   output logic signed [tvcc_pkg::OUT_BITS-1:0]        rsp_supply_voltage,
   output logic                                        rsp_divide_fault
);

   localparam int SB   = SAMPLE_BITS;
   localparam int NVB  = SB + tvcc_pkg::VOLT_BITS;
   localparam int DW   = (2*SB > NVB) ? 2*SB : NVB;
   localparam int OB   = tvcc_pkg::OUT_BITS;
   localparam int MB   = tvcc_pkg::MAG_BITS;
   localparam int XB   = tvcc_pkg::X_BITS;
   localparam int PB   = tvcc_pkg::PROD_BITS;
   localparam int QB   = PB - tvcc_pkg::RECIP_SHIFT;
   localparam int TB   = QB + 2;

   typedef struct packed {
      logic               valid;
      tvcc_pkg::kind_type kind;
      logic [OB-1:0]      val_a;
      logic [OB-1:0]      val_b;
   } side_type;

   function automatic logic [OB-1:0] sat_u(input logic [31:0] v);
      sat_u = (v > 32'(tvcc_pkg::OUT_MAX)) ? OB'(tvcc_pkg::OUT_MAX) : v[OB-1:0];
   endfunction

   // ---------------- divider stages, one quotient bit each ----------------
   logic               vld_ff  [DW];
   logic               vld_in  [DW];
   tvcc_pkg::kind_type kind_ff [DW];
   tvcc_pkg::kind_type kind_in [DW];
   logic [SB-1:0]      a_ff    [DW];
   logic [SB-1:0]      a_in    [DW];
   logic [SB-1:0]      b_ff    [DW];
   logic [SB-1:0]      b_in    [DW];
   logic [SB-1:0]      dv_ff   [DW];
   logic [SB-1:0]      dv_in   [DW];
   logic [SB-1:0]      rq_ff   [DW];
   logic [SB-1:0]      rq_in   [DW];
   logic [SB-1:0]      rv_ff   [DW];
   logic [SB-1:0]      rv_in   [DW];
   logic [DW-1:0]      nq_ff   [DW];
   logic [DW-1:0]      nq_in   [DW];
   logic [DW-1:0]      nv_ff   [DW];
   logic [DW-1:0]      nv_in   [DW];

   always_comb begin
      logic               cv;
      tvcc_pkg::kind_type ck;
      logic [SB-1:0]      ca, cb, cd, crq, crv;
      logic [DW-1:0]      cnq, cnv;
      logic [SB:0]        tq, tv, dz, dq, dvv;
      logic               geq, gev;
      for (int s = 0; s < DW; s++) begin
         if (s == 0) begin
            cv  = in_tag.valid;
            ck  = in_tag.kind;
            ca  = in_a;
            cb  = in_b;
            cd  = in_divisor;
            crq = '0;
            crv = '0;
            cnq = DW'(in_num_q);
            cnv = DW'(in_num_v);
         end else begin
            cv  = vld_ff[s-1];
            ck  = kind_ff[s-1];
            ca  = a_ff[s-1];
            cb  = b_ff[s-1];
            cd  = dv_ff[s-1];
            crq = rq_ff[s-1];
            crv = rv_ff[s-1];
            cnq = nq_ff[s-1];
            cnv = nv_ff[s-1];
         end
         tq  = {crq, cnq[DW-1]};
         tv  = {crv, cnv[DW-1]};
         dz  = {1'b0, cd};
         geq = (tq >= dz);
         gev = (tv >= dz);
         dq  = tq - dz;
         dvv = tv - dz;
         vld_in[s]  = cv;
         kind_in[s] = ck;
         a_in[s]    = ca;
         b_in[s]    = cb;
         dv_in[s]   = cd;
         rq_in[s]   = geq ? dq[SB-1:0] : tq[SB-1:0];
         rv_in[s]   = gev ? dvv[SB-1:0] : tv[SB-1:0];
         // numerator bits shift out on top, quotient bits fill in below
         nq_in[s]   = {cnq[DW-2:0], geq};
         nv_in[s]   = {cnv[DW-2:0], gev};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DW; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dv_ff   <= dv_in;
      rq_ff   <= rq_in;
      rv_ff   <= rv_in;
      nq_ff   <= nq_in;
      nv_ff   <= nv_in;
   end

   // ---------------- P1: difference, clamp, voltage saturation ----------------
   side_type              side1_ff, side1_in;
   logic                  neg1_ff, neg1_in;
   logic [MB-1:0]         mag1_ff, mag1_in;
   logic signed [DW+1:0]  diff, lim;

   always_comb begin
      diff = $signed((DW+2)'(a_ff[DW-1])) - $signed((DW+2)'(nq_ff[DW-1]));
      lim  = $signed((DW+2)'(tvcc_pkg::D_CLAMP));
      if (diff > lim) begin
         neg1_in = 1'b0;
         mag1_in = MB'(tvcc_pkg::D_CLAMP);
      end else if (diff < -lim) begin
         neg1_in = 1'b1;
         mag1_in = MB'(tvcc_pkg::D_CLAMP);
      end else if (diff < 0) begin
         neg1_in = 1'b1;
         mag1_in = MB'(-diff);
      end else begin
         neg1_in = 1'b0;
         mag1_in = MB'(diff);
      end
      side1_in.valid = vld_ff[DW-1];
      side1_in.kind  = kind_ff[DW-1];
      case (kind_ff[DW-1])
         tvcc_pkg::KIND_PASS: begin
            side1_in.val_a = sat_u(32'(a_ff[DW-1]));
            side1_in.val_b = sat_u(32'(b_ff[DW-1]));
         end
         tvcc_pkg::KIND_CONV: begin
            side1_in.val_a = '0;
            side1_in.val_b = sat_u(32'(nv_ff[DW-1]));
         end
         default: begin
            side1_in.val_a = '0;
            side1_in.val_b = '0;
         end
      endcase
   end

   // ---------------- P2..P4: |d|*1250/667 via reciprocal ----------------
   side_type         side2_ff, side3_ff, side4_ff;
   logic             neg2_ff, neg3_ff, neg4_ff;
   logic [XB-1:0]    x2_ff, x2_in, x3_ff;
   logic [PB-1:0]    p3_ff, p3_in;
   logic [QB-1:0]    q0, q4_ff, q4_in;
   logic [XB-1:0]    r4;

   assign x2_in = XB'(mag1_ff) * XB'(tvcc_pkg::GAIN_NUM);
   assign p3_in = PB'(x2_ff) * PB'(tvcc_pkg::RECIP);

   // estimate is exact or one low
   always_comb begin
      q0    = p3_ff[PB-1:tvcc_pkg::RECIP_SHIFT];
      r4    = x3_ff - XB'(32'(q0) * 32'(tvcc_pkg::GAIN_DEN));
      q4_in = (r4 >= XB'(tvcc_pkg::GAIN_DEN)) ? q0 + 1'b1 : q0;
   end

   // ---------------- P5: offset, saturation, result register ----------------
   logic signed [TB-1:0]  tsum;
   logic signed [OB-1:0]  t_sat;
   logic                  strobe_ff;
   logic signed [OB-1:0]  temp_ff, temp_in, volt_ff, volt_in;
   logic                  fault_ff, fault_in;

   always_comb begin
      if (neg4_ff) begin
         tsum = $signed(TB'(tvcc_pkg::TEMP_OFFSET)) - $signed(TB'(q4_ff));
      end else begin
         tsum = $signed(TB'(tvcc_pkg::TEMP_OFFSET)) + $signed(TB'(q4_ff));
      end
      if (tsum > $signed(TB'(tvcc_pkg::OUT_MAX))) begin
         t_sat = $signed(OB'(tvcc_pkg::OUT_MAX));
      end else if (tsum < -$signed(TB'(tvcc_pkg::OUT_MAX)) - 1) begin
         t_sat = $signed({1'b1, {(OB-1){1'b0}}});
      end else begin
         t_sat = tsum[OB-1:0];
      end
      case (side4_ff.kind)
         tvcc_pkg::KIND_CONV: temp_in = t_sat;
         default:             temp_in = $signed(side4_ff.val_a);
      endcase
      volt_in  = $signed(side4_ff.val_b);
      fault_in = (side4_ff.kind == tvcc_pkg::KIND_FAULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
         side4_ff.valid <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         side1_ff.valid <= side1_in.valid;
         side2_ff.valid <= side1_ff.valid;
         side3_ff.valid <= side2_ff.valid;
         side4_ff.valid <= side3_ff.valid;
         strobe_ff      <= side4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff.kind  <= side1_in.kind;
      side1_ff.val_a <= side1_in.val_a;
      side1_ff.val_b <= side1_in.val_b;
      side2_ff.kind  <= side1_ff.kind;
      side2_ff.val_a <= side1_ff.val_a;
      side2_ff.val_b <= side1_ff.val_b;
      side3_ff.kind  <= side2_ff.kind;
      side3_ff.val_a <= side2_ff.val_a;
      side3_ff.val_b <= side2_ff.val_b;
      side4_ff.kind  <= side3_ff.kind;
      side4_ff.val_a <= side3_ff.val_a;
      side4_ff.val_b <= side3_ff.val_b;
      neg1_ff        <= neg1_in;
      mag1_ff        <= mag1_in;
      neg2_ff        <= neg1_ff;
      x2_ff          <= x2_in;
      neg3_ff        <= neg2_ff;
      x3_ff          <= x2_ff;
      p3_ff          <= p3_in;
      neg4_ff        <= neg3_ff;
      q4_ff          <= q4_in;
      temp_ff        <= temp_in;
      volt_ff        <= volt_in;
      fault_ff       <= fault_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_temperature    = temp_ff;
   assign rsp_supply_voltage = volt_ff;
   assign rsp_divide_fault   = fault_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DW-1] && (kind_ff[DW-1] == tvcc_pkg::KIND_CONV)
      |-> (rq_ff[DW-1] < dv_ff[DW-1]) && (rv_ff[DW-1] < dv_ff[DW-1]))
      else $error("divider remainder not below divisor");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_divide_fault |-> (rsp_temperature == '0)
                                         && (rsp_supply_voltage == '0))
      else $error("fault beat carries nonzero results");
`endif

endmodule

/* rtl/temp_vref_calibrated_convert_unit.sv */
// Top level of the calibrated temperature / supply voltage converter.
// Path from start to rsp_strobe: front end, queue, one divider stage per dividend bit with
//   DW = max(2*SAMPLE_BITS, SAMPLE_BITS+9) dividend bits (24 at 12-bit samples), then scaling.
// Throughput: one item per cycle; busy stays low since the back end drains every beat.
// Results cannot be stalled; each appears for one cycle with rsp_strobe.
// Synchronous reset empties the pipeline and loads the factory calibration words.
module temp_vref_calibrated_convert_unit #(
   parameter int SAMPLE_BITS = tvcc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic [SAMPLE_BITS-1:0]                req_temp_sample,
   input  logic [SAMPLE_BITS-1:0]                req_vref_sample,
   output logic                                  rsp_strobe,
   output logic signed [tvcc_pkg::OUT_BITS-1:0]  rsp_temperature,
   output logic signed [tvcc_pkg::OUT_BITS-1:0]  rsp_supply_voltage,
   output logic                                  rsp_divide_fault,
   input  logic                                  csr_write_enable,
   input  logic [tvcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [SAMPLE_BITS-1:0]                csr_write_data
);

   localparam int SB      = SAMPLE_BITS;
   localparam int NVB     = SB + tvcc_pkg::VOLT_BITS;
   localparam int DW      = (2*SB > NVB) ? 2*SB : NVB;
   localparam int LATENCY = DW + 8;
   localparam int QW      = 3*SB + 2*SB + NVB;

   logic                accept;
   tvcc_pkg::tag_type   f_tag, q_tag;
   logic [SB-1:0]       f_a, f_b, f_div, q_a, q_b, q_div;
   logic [2*SB-1:0]     f_nq, q_nq;
   logic [NVB-1:0]      f_nv, q_nv;
   logic [QW-1:0]       q_data;
   logic                q_full;

   assign accept = start && !busy;
   assign busy   = q_full;

   tvcc_front #(.SAMPLE_BITS(SB)) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_opcode       (req_opcode),
      .req_temp_sample  (req_temp_sample),
      .req_vref_sample  (req_vref_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_tag          (f_tag),
      .out_a            (f_a),
      .out_b            (f_b),
      .out_divisor      (f_div),
      .out_num_q        (f_nq),
      .out_num_v        (f_nv)
   );

   tvcc_queue #(.DATA_BITS(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_tag  (f_tag),
      .push_data ({f_a, f_b, f_div, f_nq, f_nv}),
      .pop_tag   (q_tag),
      .pop_data  (q_data),
      .full      (q_full)
   );

   assign {q_a, q_b, q_div, q_nq, q_nv} = q_data;

   tvcc_back #(.SAMPLE_BITS(SB)) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_tag             (q_tag),
      .in_a               (q_a),
      .in_b               (q_b),
      .in_divisor         (q_div),
      .in_num_q           (q_nq),
      .in_num_v           (q_nv),
      .rsp_strobe         (rsp_strobe),
      .rsp_temperature    (rsp_temperature),
      .rsp_supply_voltage (rsp_supply_voltage),
      .rsp_divide_fault   (rsp_divide_fault)
   );

`ifndef SYNTHESIS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("result beat missing at fixed latency");
`endif

endmodule
